FILE: rtl/bqd_pkg.sv
// bqd_pkg: shared constants, register indices and lane control type
// for the biquad filter core. No dependencies.
package bqd_pkg;

  // fixed formats of the configuration registers and accumulator
  localparam int COEF_BITS     = 32;
  localparam int AMP_BITS      = 31;
  localparam int AMP_FRAC_BITS = 24;
  localparam int ACC_BITS      = 64;
  localparam int Y_GUARD_BITS  = 4;
  localparam int NUM_LANES     = 5;
  localparam int CNT_BITS      = $clog2(ACC_BITS);
  localparam int CFG_IDX_BITS  = 3;

  // configuration register indices
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FF_COEF0  = 3'd0,
    REG_FF_COEF1  = 3'd1,
    REG_FF_COEF2  = 3'd2,
    REG_FB_COEF1  = 3'd3,
    REG_FB_COEF2  = 3'd4,
    REG_AMP_SCALE = 3'd5
  } bqd_reg_t;

  // control for the serial multiplier lanes and column adder
  typedef struct packed {
    logic load;  // take new operands, clear accumulators
    logic step;  // consume one multiplier bit, emit one product bit
    logic msb;   // multiplier sign bit this cycle (negative weight)
    logic rnd;   // inject the rounding one into this column
  } bqd_ctl_t;

endpackage

FILE: rtl/bqd_ser_mul.sv
// bqd_ser_mul: serial-parallel signed multiplier lane, one product bit per
// cycle while step is set, least significant first. Depends on bqd_pkg.
module bqd_ser_mul import bqd_pkg::*; #(
  parameter int MW = 29
) (
  input  logic                 clk,
  input  bqd_ctl_t             ctl,
  input  logic signed [MW-1:0] mcand_i,
  input  logic [COEF_BITS-1:0] mplr_i,
  output logic                 bit_o
);

  localparam int AW = MW + 2;

  logic signed [MW-1:0]  mc_r;
  logic [COEF_BITS-1:0]  mp_r;
  logic signed [AW-1:0]  acc_r;
  logic signed [AW-1:0]  pp;
  logic signed [AW-1:0]  sum;

  // partial product: sign bit of the multiplier carries negative weight
  always_comb begin
    if (mp_r[0]) begin
      pp = ctl.msb ? -AW'(mc_r) : AW'(mc_r);
    end else begin
      pp = '0;
    end
    sum   = acc_r + pp;
    bit_o = sum[0];
  end

  // operand and partial sum registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mc_r  <= mcand_i;
      mp_r  <= mplr_i;
      acc_r <= '0;
    end else if (ctl.step) begin
      mp_r  <= mp_r >> 1;
      acc_r <= sum >>> 1;
    end
  end

endmodule

FILE: rtl/bqd_col_add.sv
// bqd_col_add: bit-serial column adder over the lane product streams,
// collecting the sum mod 2^64 in a shift register. Depends on bqd_pkg.
module bqd_col_add import bqd_pkg::*; #(
  parameter int NL = 5
) (
  input  logic                clk,
  input  bqd_ctl_t            ctl,
  input  logic [NL-1:0]       bits_i,
  output logic [ACC_BITS-1:0] res_o
);

  localparam int SW = $clog2(2 * NL + 2) + 1;

  logic [SW-2:0]       carry_r;
  logic [ACC_BITS-1:0] res_r;
  logic [SW-1:0]       col_sum;

  // one column: carry plus rounding bit plus one bit from each lane
  always_comb begin
    col_sum = SW'(carry_r) + SW'(ctl.rnd);
    for (int i = 0; i < NL; i++) begin
      col_sum = col_sum + SW'(bits_i[i]);
    end
  end

  // carry and result shift register, filled from the top
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      carry_r <= '0;
    end else if (ctl.step) begin
      carry_r <= col_sum[SW-1:1];
      res_r   <= {col_sum[0], res_r[ACC_BITS-1:1]};
    end
  end

  assign res_o = res_r;

endmodule

FILE: rtl/biquad_iir_filter_core.sv
// biquad_iir_filter_core: direct form I biquad with bit-serial multiply
// and accumulate. Depends on bqd_pkg, bqd_ser_mul and bqd_col_add.
//
// Usage:
// - input channel in_valid/in_ready carries one signed sample per beat;
//   the output channel out_valid/out_ready returns one filtered sample
//   and a clip flag per input beat, in order.
// - configuration beats on cfg_valid/cfg_ready (always ready) write the
//   five Q4.28 coefficients and the Q7.24 amplitude scale by index;
//   unknown indices are dropped. Write them only while the block is idle.
// - an accepted sample runs through five serial multiplier lanes (one
//   product bit per cycle, rounding one injected), a saturation step in
//   S_SAT1, then output scaling on lane zero in S_MUL2 and S_OUT to
//   register the result; only then is the next sample taken. The 64-bit
//   serial accumulation runs twice per sample.
// - the result sits in an output register; in_ready returns while it
//   waits. A stalled receiver holds the block only once the next result
//   is ready and the register is still full.
// - synchronous reset clears the delay line, restores the default
//   coefficients (unity pass-through) and empties the output register.
module biquad_iir_filter_core import bqd_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data
);

  localparam int Y_BITS = SAMPLE_BITS + Y_GUARD_BITS;
  localparam int MUL_W  = Y_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_SAT1,
    S_MUL2,
    S_OUT
  } state_t;

  // configuration registers
  logic [COEF_BITS-1:0] ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;
  logic [AMP_BITS-1:0]  amp_r;

  // sequencer and datapath registers
  state_t                   state_r, state_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] x_cur_r, x_cur_nxt;
  logic signed [SAMPLE_BITS-1:0] xd1_r, xd1_nxt, xd2_r, xd2_nxt;
  logic signed [Y_BITS-1:0] yd1_r, yd1_nxt, yd2_r, yd2_nxt;
  logic                     clip_r, clip_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                     out_clip_r, out_clip_nxt;

  // lane operands and results
  bqd_ctl_t                 ctl;
  logic signed [MUL_W-1:0]  lane_mc [NUM_LANES];
  logic [COEF_BITS-1:0]     lane_mp [NUM_LANES];
  logic [NUM_LANES-1:0]     lane_bit;
  logic [ACC_BITS-1:0]      acc_res;

  // rounding and saturation
  logic signed [ACC_BITS-1:0]   acc_y_sh, acc_o_sh;
  logic [ACC_BITS-Y_BITS:0]     y_top;
  logic [ACC_BITS-SAMPLE_BITS:0] o_top;
  logic                         y_ovf, o_ovf;
  logic signed [Y_BITS-1:0]     y_sat;
  logic signed [SAMPLE_BITS-1:0] o_sat;
  logic                         last_bit;

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0_r <= COEF_BITS'(1) << COEF_FRAC_BITS;
      ff1_r <= '0;
      ff2_r <= '0;
      fb1_r <= '0;
      fb2_r <= '0;
      amp_r <= AMP_BITS'(1) << AMP_FRAC_BITS;
    end else if (cfg_valid) begin
      case (bqd_reg_t'(cfg_index))
        REG_FF_COEF0:  ff0_r <= cfg_data;
        REG_FF_COEF1:  ff1_r <= cfg_data;
        REG_FF_COEF2:  ff2_r <= cfg_data;
        REG_FB_COEF1:  fb1_r <= cfg_data;
        REG_FB_COEF2:  fb2_r <= cfg_data;
        REG_AMP_SCALE: amp_r <= cfg_data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // lane control
  assign last_bit = (cnt_r == CNT_BITS'(ACC_BITS - 1));
  always_comb begin
    ctl.load = ((state_r == S_IDLE) && in_valid) || (state_r == S_SAT1);
    ctl.step = (state_r == S_MUL1) || (state_r == S_MUL2);
    ctl.msb  = (cnt_r == CNT_BITS'(COEF_BITS - 1));
    ctl.rnd  = ((state_r == S_MUL1) && (cnt_r == CNT_BITS'(COEF_FRAC_BITS - 1))) ||
               ((state_r == S_MUL2) && (cnt_r == CNT_BITS'(AMP_FRAC_BITS - 1)));
  end

  // lane operands: filter taps on accept, output scaling after saturation
  always_comb begin
    if (state_r == S_IDLE) begin
      lane_mc[0] = MUL_W'(in_sample_in);
      lane_mc[1] = MUL_W'(xd1_r);
      lane_mc[2] = MUL_W'(xd2_r);
      lane_mc[3] = -MUL_W'(yd1_r);
      lane_mc[4] = -MUL_W'(yd2_r);
      lane_mp[0] = ff0_r;
      lane_mp[1] = ff1_r;
      lane_mp[2] = ff2_r;
      lane_mp[3] = fb1_r;
      lane_mp[4] = fb2_r;
    end else begin
      lane_mc[0] = MUL_W'(y_sat);
      lane_mp[0] = COEF_BITS'(amp_r);
      for (int i = 1; i < NUM_LANES; i++) begin
        lane_mc[i] = '0;
        lane_mp[i] = '0;
      end
    end
  end

  // serial multiplier lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bqd_ser_mul #(
      .MW (MUL_W)
    ) u_mul (
      .clk     (clk),
      .ctl     (ctl),
      .mcand_i (lane_mc[g]),
      .mplr_i  (lane_mp[g]),
      .bit_o   (lane_bit[g])
    );
  end

  // column adder and accumulator shift register
  bqd_col_add #(
    .NL (NUM_LANES)
  ) u_col (
    .clk    (clk),
    .ctl    (ctl),
    .bits_i (lane_bit),
    .res_o  (acc_res)
  );

  // feedback value: floor shift and saturate to the feedback width
  always_comb begin
    acc_y_sh = $signed(acc_res) >>> COEF_FRAC_BITS;
    y_top    = acc_y_sh[ACC_BITS-1:Y_BITS-1];
    y_ovf    = !((&y_top) || !(|y_top));
    if (y_ovf) begin
      y_sat = acc_y_sh[ACC_BITS-1] ? {1'b1, {(Y_BITS-1){1'b0}}}
                                   : {1'b0, {(Y_BITS-1){1'b1}}};
    end else begin
      y_sat = acc_y_sh[Y_BITS-1:0];
    end
  end

  // scaled output: floor shift and saturate to the sample width
  always_comb begin
    acc_o_sh = $signed(acc_res) >>> AMP_FRAC_BITS;
    o_top    = acc_o_sh[ACC_BITS-1:SAMPLE_BITS-1];
    o_ovf    = !((&o_top) || !(|o_top));
    if (o_ovf) begin
      o_sat = acc_o_sh[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      o_sat = acc_o_sh[SAMPLE_BITS-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    x_cur_nxt      = x_cur_r;
    xd1_nxt        = xd1_r;
    xd2_nxt        = xd2_r;
    yd1_nxt        = yd1_r;
    yd2_nxt        = yd2_r;
    clip_nxt       = clip_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_cur_nxt = in_sample_in;
          cnt_nxt   = '0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (last_bit) begin
          state_nxt = S_SAT1;
        end
      end
      S_SAT1: begin
        clip_nxt  = y_ovf;
        xd2_nxt   = xd1_r;
        xd1_nxt   = x_cur_r;
        yd2_nxt   = yd1_r;
        yd1_nxt   = y_sat;
        cnt_nxt   = '0;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (last_bit) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_sample_nxt = o_sat;
          out_clip_nxt   = clip_r | o_ovf;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer state, delay line and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      xd1_r       <= '0;
      xd2_r       <= '0;
      yd1_r       <= '0;
      yd2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      x_cur_r      <= x_cur_nxt;
      xd1_r        <= xd1_nxt;
      xd2_r        <= xd2_nxt;
      yd1_r        <= yd1_nxt;
      yd2_r        <= yd2_nxt;
      clip_r       <= clip_nxt;
      out_valid_r  <= out_valid_nxt;
      out_sample_r <= out_sample_nxt;
      out_clip_r   <= out_clip_nxt;
    end
  end

endmodule

FILE: dv/bqd_filter_check_pkg.sv
// bqd_filter_check_pkg: expected-result tracking for the biquad filter core
// testbench. Depends on bqd_pkg for register indices and fixed formats.
package bqd_filter_check_pkg;
  import bqd_pkg::*;

  localparam int SMP_BITS    = 24;
  localparam int FRAC_BITS   = 28;
  localparam int FB_BITS     = SMP_BITS + Y_GUARD_BITS;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [SMP_BITS-1:0] sample;
    logic                clipped;
  } filt_result_t;

  class biquad_checker;
    // coefficient copies sign-extended, gain copy zero-extended
    longint ff0, ff1, ff2, fb1, fb2, gain;
    // delay line
    longint x_d1, x_d2, y_d1, y_d2;
    filt_result_t expected_q[$];
    int errors, results, clips, samples;

    function new();
      ff0  = longint'(1) <<< FRAC_BITS;
      ff1  = 0;
      ff2  = 0;
      fb1  = 0;
      fb2  = 0;
      gain = longint'(1) <<< AMP_FRAC_BITS;
      x_d1 = 0;
      x_d2 = 0;
      y_d1 = 0;
      y_d2 = 0;
    endfunction

    // register write, unknown indices dropped
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
      case (idx)
        REG_FF_COEF0:  ff0 = longint'($signed(data));
        REG_FF_COEF1:  ff1 = longint'($signed(data));
        REG_FF_COEF2:  ff2 = longint'($signed(data));
        REG_FB_COEF1:  fb1 = longint'($signed(data));
        REG_FB_COEF2:  fb2 = longint'($signed(data));
        REG_AMP_SCALE: gain = longint'(data[AMP_BITS-1:0]);
        default: ;
      endcase
    endfunction

    // signed saturation to a given width, flags a hit
    function longint clamp(longint v, int bits, inout bit hit);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    // filter one accepted sample and queue the expected output
    function void note_sample(logic [SMP_BITS-1:0] x_in);
      longint x, acc, y, o;
      bit     hit;
      x   = longint'($signed(x_in));
      hit = 1'b0;
      acc = ff0 * x + ff1 * x_d1 + ff2 * x_d2 - fb1 * y_d1 - fb2 * y_d2
            + (longint'(1) <<< (FRAC_BITS - 1));
      y   = clamp(acc >>> FRAC_BITS, FB_BITS, hit);
      acc = y * gain + (longint'(1) <<< (AMP_FRAC_BITS - 1));
      o   = clamp(acc >>> AMP_FRAC_BITS, SMP_BITS, hit);
      y_d2 = y_d1;
      y_d1 = y;
      x_d2 = x_d1;
      x_d1 = x;
      expected_q.push_back('{sample: o[SMP_BITS-1:0], clipped: hit});
      samples++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("error: %s", msg);
    endtask

    // compare one output beat with the oldest expectation
    task check_output(logic [SMP_BITS-1:0] s, logic c);
      filt_result_t e;
      results++;
      if (c === 1'b1)
        clips++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("output %0d arrived with no sample pending (%0d, clip %b)",
                                  results, $signed(s), c));
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample)
        report_mismatch($sformatf("output %0d sample %0d, expected %0d",
                                  results, $signed(s), $signed(e.sample)));
      if (c !== e.clipped)
        report_mismatch($sformatf("output %0d clip flag %b, expected %b",
                                  results, c, e.clipped));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
// tb_top: drives samples and coefficient writes into biquad_iir_filter_core
// and checks every output beat. Depends on bqd_pkg and bqd_filter_check_pkg.
module tb_top;
  import bqd_pkg::*;
  import bqd_filter_check_pkg::*;

  localparam int LIMIT_CYCLES  = 5_000_000;
  localparam int LATENCY       = 131;
  localparam int PHASE_ITEMS   = 200;
  localparam int RANDOM_PHASES = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [COEF_BITS-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [COEF_BITS-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_BITS-1:0] COEF_ONE = 32'h1000_0000;
  localparam logic [COEF_BITS-1:0] GAIN_ONE = 32'h0100_0000;
  localparam logic [COEF_BITS-1:0] COEF_CORNERS [6] = '{
    COEF_MIN, COEF_MAX, 32'h0, COEF_ONE, 32'hF000_0000, 32'hFFFF_FFFF};
  localparam logic [COEF_BITS-1:0] GAIN_CORNERS [4] = '{
    32'h0, 32'hFFFF_FFFF, GAIN_ONE, COEF_MAX};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SMP_BITS-1:0] in_sample_in;
  logic                out_valid;
  logic                out_ready;
  logic [SMP_BITS-1:0] out_sample_out;
  logic                out_clipped;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COEF_BITS-1:0]    cfg_data;

  biquad_checker chk = new();
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;
  int settings;

  biquad_iir_filter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, with the odd long stall to fill the output register
  always @(posedge clk) begin
    if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 1999) == 0) begin
      recv_hold <= $urandom_range(100, 300);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // output beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chk.check_output(out_sample_out, out_clipped);
  end

  task automatic wait_idle();
    while (chk.pending() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    chk.write_reg(idx, data);
  endtask

  // load a full coefficient set once the filter has drained
  task automatic program_filter(logic [COEF_BITS-1:0] b0, logic [COEF_BITS-1:0] b1,
                                logic [COEF_BITS-1:0] b2, logic [COEF_BITS-1:0] a1,
                                logic [COEF_BITS-1:0] a2, logic [COEF_BITS-1:0] g,
                                bit spare);
    wait_idle();
    if (spare) begin
      write_reg(REG_SPARE_LO, $urandom());
      write_reg(REG_SPARE_HI, $urandom());
    end
    write_reg(REG_FF_COEF0, b0);
    write_reg(REG_FF_COEF1, b1);
    write_reg(REG_FF_COEF2, b2);
    write_reg(REG_FB_COEF1, a1);
    write_reg(REG_FB_COEF2, a2);
    write_reg(REG_AMP_SCALE, g);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // one input beat, with a random gap ahead of it
  task automatic send_sample(logic [SMP_BITS-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (send_idle_pct != 0 && $urandom_range(0, 59) == 0)
      gap += $urandom_range(20, 200);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    chk.note_sample(s);
  endtask

  function automatic logic [SMP_BITS-1:0] pick_sample();
    logic [SMP_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = 24'hFFFFFF;
          default: s = 24'h000000;
        endcase
      end
      1, 2: s = SMP_BITS'($urandom_range(0, 2000)) - SMP_BITS'(1000);
      default: s = SMP_BITS'($urandom());
    endcase
    return s;
  endfunction

  initial begin
    logic [COEF_BITS-1:0] r [6];
    longint a2, bnd;
    int     mode;
    in_valid      <= 1'b0;
    in_sample_in  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_FF_COEF0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 74;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // unity pass-through straight out of reset
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    in_valid <= 1'b0;

    // unstable filter, largest gain: feedback and output saturate
    program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, 32'hFFFF_FFFF, 1'b1);
    send_sample(24'h7FFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h800000);
    send_sample(24'd100);
    in_valid <= 1'b0;

    // most negative coefficients, zero gain
    program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 32'h0, 1'b0);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000001);
    in_valid <= 1'b0;

    // unity filter with top gain: output alone clips
    program_filter(COEF_ONE, 32'h0, 32'h0, 32'h0, 32'h0, COEF_MAX, 1'b0);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    send_sample(24'd70000);
    send_sample(-24'd70000);
    send_sample(24'h000000);
    in_valid <= 1'b0;

    // random coefficient sets, idling pattern changes by thirds
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 74;
      end else if (ph < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mode = ph % 3;
      case (mode)
        // stable second-order section
        0: begin
          a2  = longint'($urandom_range(0, 480000000)) - 240000000;
          bnd = ((longint'(1) <<< FRAC_BITS) + a2) * 9 / 10;
          for (int i = 0; i < 3; i++)
            r[i] = COEF_BITS'(longint'($urandom_range(0, 1 << 28)) - (longint'(1) <<< 27));
          r[3] = COEF_BITS'(longint'($urandom_range(0, 32'(2 * bnd))) - bnd);
          r[4] = COEF_BITS'(a2);
          r[5] = $urandom_range(0, 1 << 26);
        end
        // anything the registers hold
        1: begin
          for (int i = 0; i < 6; i++)
            r[i] = $urandom();
        end
        // corner values
        default: begin
          for (int i = 0; i < 5; i++)
            r[i] = COEF_CORNERS[$urandom_range(0, 5)];
          r[5] = GAIN_CORNERS[$urandom_range(0, 3)];
        end
      endcase
      program_filter(r[0], r[1], r[2], r[3], r[4], r[5], $urandom_range(0, 1) == 1);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(pick_sample());
      in_valid <= 1'b0;
    end

    wait_idle();
    repeat (LATENCY) @(posedge clk);

    $display("covered %0d samples through %0d coefficient settings under stalls on both sides",
             chk.samples, settings);
    $display("%0d outputs checked, %0d of them clipped", chk.results, chk.clips);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (chk.pending() != 0)
        $display("error: %0d expected outputs never arrived", chk.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bqd_pkg.sv
rtl/bqd_ser_mul.sv
rtl/bqd_col_add.sv
rtl/biquad_iir_filter_core.sv
dv/bqd_filter_check_pkg.sv
dv/tb_top.sv
